@@ design/cbm_pkg.sv @@
`timescale 1ns / 1ps

package cbm_pkg;

  localparam int MAX_RAM_BANKS  = 16;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int ROM_BANK_BYTES = 16384;

  localparam int RAM_DEPTH = MAX_RAM_BANKS * RAM_BANK_BYTES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int RAM_OFF_W = $clog2(RAM_BANK_BYTES);
  localparam int ROM_OFF_W = $clog2(ROM_BANK_BYTES);

  localparam int RAM_SEL_W = 4;
  localparam int ROM_BANK_W = 9;
  localparam int ROM_ADDR_W = 23;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [15:0] RAM_EN_LIMIT   = 16'h2000;
  localparam logic [15:0] ROM_LO_LIMIT   = 16'h3000;
  localparam logic [15:0] ROM_HI_LIMIT   = 16'h4000;
  localparam logic [15:0] RAM_SEL_LIMIT  = 16'h6000;
  localparam logic [3:0]  RAM_EN_KEY     = 4'hA;
  localparam logic [3:0]  RUMBLE_MASK    = 4'h3;
  localparam logic [3:0]  FULL_SEL_MASK  = 4'hF;
  localparam logic [7:0]  OPEN_BUS_BYTE  = 8'hFF;

  typedef enum logic [1:0] {
    CMD_CTRL_WR = 2'd0,
    CMD_ROM_RD  = 2'd1,
    CMD_RAM_RD  = 2'd2,
    CMD_RAM_WR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_RAM_BANKS = 2'd0,
    REG_RUMBLE    = 2'd1,
    REG_BATTERY   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic                  is_rom_read;
    logic [ROM_ADDR_W-1:0] rom_byte_address;
    logic [7:0]            read_data;
    logic [ROM_BANK_W-1:0] current_bank;
    logic                  save_stale;
  } out_item_t;

endpackage

@@ design/cartridge_bank_mapper_unit.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o  | cbm_pkg::in_item_t
// out     | output    | out_valid_o / out_stall_i| cbm_pkg::out_item_t
// cfg     | input     | APB psel/penable/pready  | 32-bit registers at 4*i
// One item per cycle while in_stall_o is low; a ROM or RAM read result passes the
// access stage, with the registered read of the save RAM, and then the output register.
// After reset a clearing pass zeroes every RAM entry, with in_stall_o high throughout.
// A stalled result holds; one more read waits behind it before the input stalls.

module cartridge_bank_mapper_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cbm_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cbm_pkg::out_item_t            out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbm_pkg::PADDR_W-1:0]   paddr,
  input  logic [cbm_pkg::PDATA_W-1:0]   pwdata,
  output logic [cbm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  import cbm_pkg::*;

  // configuration
  logic [4:0] ram_banks_q;
  logic       rumble_q;
  logic       battery_q;
  logic       cfg_wr;
  reg_idx_e   cfg_idx;

  // mapper registers
  logic                 ram_en_q;
  logic [7:0]           rom_lo_q;
  logic                 rom_hi_q;
  logic [RAM_SEL_W-1:0] ram_sel_q;
  logic                 stale_q, stale_d;

  // clearing pass
  logic              clr_busy_q;
  logic [RAM_AW-1:0] clr_cnt_q;

  // access stage
  cmd_e                  in_cmd;
  logic                  accept;
  logic [RAM_SEL_W-1:0]  bank_mask;
  logic [RAM_SEL_W-1:0]  eff_bank;
  logic                  ram_hit;
  logic [RAM_AW-1:0]     ram_idx;
  logic [ROM_BANK_W-1:0] rom_bank;

  logic                  s1_valid_q;
  cmd_e                  s1_cmd_q;
  logic                  s1_hit_q;
  logic [RAM_AW-1:0]     s1_idx_q;
  logic [7:0]            s1_wdata_q;
  logic [ROM_ADDR_W-1:0] s1_rom_addr_q;
  logic [ROM_BANK_W-1:0] s1_bank_q;
  logic                  s1_has_result;
  logic                  s1_blocked;
  logic                  s1_leave;
  logic [7:0]            old_byte;

  // last write to the RAM, covers a read issued in the same cycle
  logic              fwd_valid_q;
  logic [RAM_AW-1:0] fwd_idx_q;
  logic [7:0]        fwd_data_q;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic              upd_we;

  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t out_item_d;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_RAM_BANKS: prdata = PDATA_W'(ram_banks_q);
      REG_RUMBLE:    prdata = PDATA_W'(rumble_q);
      REG_BATTERY:   prdata = PDATA_W'(battery_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_banks_q <= '0;
      rumble_q    <= 1'b0;
      battery_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RAM_BANKS: ram_banks_q <= pwdata[4:0];
        REG_RUMBLE:    rumble_q    <= pwdata[0];
        REG_BATTERY:   battery_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // ---------------- accept and decode ----------------
  assign in_cmd        = cmd_e'(in_item_i.command);
  assign s1_has_result = (s1_cmd_q != CMD_RAM_WR);
  assign s1_blocked    = s1_valid_q && s1_has_result && out_valid_q && out_stall_i;
  assign s1_leave      = s1_valid_q && !s1_blocked;
  assign in_stall_o    = clr_busy_q || s1_blocked;
  assign accept        = in_valid_i && !in_stall_o;

  assign bank_mask = (rumble_q ? RUMBLE_MASK : FULL_SEL_MASK) &
                     RAM_SEL_W'(ram_banks_q - 5'd1);
  assign eff_bank  = ram_sel_q & bank_mask;
  assign ram_hit   = ram_en_q && (ram_banks_q != '0) &&
                     ({1'b0, eff_bank} < 5'(MAX_RAM_BANKS));
  assign ram_idx   = RAM_AW'({eff_bank, in_item_i.bus_address[RAM_OFF_W-1:0]});
  assign rom_bank  = {rom_hi_q, rom_lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_en_q  <= 1'b0;
      rom_lo_q  <= '0;
      rom_hi_q  <= 1'b0;
      ram_sel_q <= '0;
    end else if (accept && in_cmd == CMD_CTRL_WR) begin
      priority if (in_item_i.bus_address < RAM_EN_LIMIT) begin
        ram_en_q <= (in_item_i.write_data[3:0] == RAM_EN_KEY);
      end else if (in_item_i.bus_address < ROM_LO_LIMIT) begin
        rom_lo_q <= in_item_i.write_data;
      end else if (in_item_i.bus_address < ROM_HI_LIMIT) begin
        rom_hi_q <= in_item_i.write_data[0];
      end else if (in_item_i.bus_address < RAM_SEL_LIMIT) begin
        ram_sel_q <= in_item_i.write_data[RAM_SEL_W-1:0];
      end else begin
        // control writes from 0x6000 up are ignored
      end
    end
  end

  // ---------------- access stage ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= (in_cmd != CMD_CTRL_WR);
    end else if (s1_leave) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q      <= in_cmd;
      s1_hit_q      <= ram_hit;
      s1_idx_q      <= ram_idx;
      s1_wdata_q    <= in_item_i.write_data;
      s1_rom_addr_q <= {rom_bank, in_item_i.bus_address[ROM_OFF_W-1:0]};
      s1_bank_q     <= rom_bank;
    end
  end

  assign old_byte = (fwd_valid_q && fwd_idx_q == s1_idx_q) ? fwd_data_q : ram_rdata;
  assign upd_we   = s1_leave && s1_cmd_q == CMD_RAM_WR && s1_hit_q &&
                    old_byte != s1_wdata_q;
  assign stale_d  = stale_q || (upd_we && battery_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_q     <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      stale_q <= stale_d;
      if (upd_we) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_we) begin
      fwd_idx_q  <= s1_idx_q;
      fwd_data_q <= s1_wdata_q;
    end
  end

  // ---------------- clearing pass ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == RAM_AW'(RAM_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign ram_we    = clr_busy_q || upd_we;
  assign ram_waddr = clr_busy_q ? clr_cnt_q : s1_idx_q;
  assign ram_wdata = clr_busy_q ? 8'h00 : s1_wdata_q;

  cbm_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_save_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(ram_idx),
    .rdata_o(ram_rdata)
  );

  // ---------------- output register ----------------
  always_comb begin
    out_item_d              = '0;
    out_item_d.current_bank = s1_bank_q;
    out_item_d.save_stale   = stale_q;
    if (s1_cmd_q == CMD_ROM_RD) begin
      out_item_d.is_rom_read      = 1'b1;
      out_item_d.rom_byte_address = s1_rom_addr_q;
    end else begin
      out_item_d.read_data = s1_hit_q ? old_byte : OPEN_BUS_BYTE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_leave && s1_has_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_leave && s1_has_result) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ design/cbm_ram.sv @@
`timescale 1ns / 1ps

module cbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: a read of the entry being written returns the old value
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/cbm_checker.sv @@
`timescale 1ns / 1ps

module cbm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input cbm_pkg::out_item_t out_item_o
);

  import cbm_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_rom_read |->
      out_item_o.rom_byte_address[ROM_ADDR_W-1:ROM_OFF_W] == out_item_o.current_bank)
    else $error("ROM address bank differs from current bank");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_rom_read |-> out_item_o.read_data == '0)
    else $error("ROM read carries RAM data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.is_rom_read |-> out_item_o.rom_byte_address == '0)
    else $error("RAM read carries a ROM address");

endmodule

bind cartridge_bank_mapper_unit cbm_checker u_cbm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);
